[rtl/core/bth_pkg.sv]
// Shared types, codes and the pair ordering for the bounded top-K heap picker.
package bth_pkg;

  // Request function codes.
  typedef enum logic [1:0] {
    FUNC_OFFER = 2'd0,
    FUNC_DRAIN = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_RSVD  = 2'd3
  } func_t;

  // One held pair: key first so that the packed vector orders by key, then id.
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] id;
  } entry_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT_CMP,
    S_DN_RD,
    S_DN_CMP,
    S_SORT_RD,
    S_SORT_SWP,
    S_EMIT_RD,
    S_EMIT_WAIT,
    S_EMPTY
  } state_t;

  // True when pair a is strictly better (smaller key, then smaller id) than b.
  function automatic logic better(entry_t a, entry_t b);
    return {a.key, a.id} < {b.key, b.id};
  endfunction

endpackage

[rtl/core/bth_req_if.sv]
// Request channel of the heap picker: function code and offered pair.
interface bth_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] sort_key;
  logic [15:0] item_id;

  modport source (output valid, output func, output sort_key, output item_id, input ready);
  modport sink (input valid, input func, input sort_key, input item_id, output ready);
endinterface

[rtl/core/bth_rsp_if.sv]
// Result channel of the heap picker: one drained pair per transfer.
interface bth_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_key;
  logic [15:0] out_id;
  logic        last;
  logic        none_held;

  modport source (output valid, output out_key, output out_id, output last,
                  output none_held, input ready);
  modport sink (input valid, input out_key, input out_id, input last,
                input none_held, output ready);
endinterface

[rtl/core/bounded_top_k_heap_picker.sv]
// Top level of the bounded top-K heap picker: sequencer around the heap memory.
//
// Usage: requests arrive on req (valid/ready). func selects offer, drain or
// clear; offers carry sort_key and item_id. Results leave on rsp (valid/ready),
// one per held pair during a drain, best pair first, last set on the final one.
// A drain with nothing held returns a single result with none_held and last set.
// cfg_wr_en/cfg_wr_data write keep_limit and empty the store; write it only
// while the block is idle.
// Operation: one request is in work at a time; req.ready is high only when the
// sequencer is idle. An offer that appends sifts the new pair up from the end
// of the heap; an offer that replaces the root sifts it down from the root. A
// rejected offer only reads the root for the compare. A drain of n pairs runs
// n - 1 heapsort passes, each a swap and a sift down, then emits the pairs in
// address order. Each heap level costs one memory read state and one
// compare/write state of the shared store.
// Results are held in an output register, so a new request is taken while the
// last result still waits; a stalled receiver holds the drain in place.
// Reset empties the store and sets keep_limit to 64; memory contents are not
// cleared, since only entries below the held count are ever read.
module bounded_top_k_heap_picker #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [6:0] cfg_wr_data,
  bth_req_if.sink    req,
  bth_rsp_if.source  rsp
);
  import bth_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  state_t        state, state_next;
  logic [6:0]    keep_limit;
  logic [CW-1:0] held, held_next;
  logic [CW-1:0] span, span_next;
  logic [CW-1:0] k, k_next;
  logic [AW-1:0] node, node_next;
  entry_t        cur, cur_next;
  logic          draining, draining_next;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  entry_t        wr_data, rd_data_a, rd_data_b;

  logic          req_fire, out_free, out_load;
  entry_t        ld_entry;
  logic          ld_last, ld_none;
  entry_t        in_entry;
  logic [CW-1:0] limit;
  logic [AW-1:0] parent;
  logic [XW-1:0] left_x, right_x, span_x;
  logic [CW-1:0] span_m1;
  state_t        sink_done;
  logic          pick_right;

  bth_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Effective limit and heap index arithmetic.
  always_comb begin
    limit = (keep_limit >= 7'(CAPACITY)) ? CW'(CAPACITY) : CW'(keep_limit);
    parent = (node - 1'b1) >> 1;
    left_x = (XW'(node) << 1) + XW'(1);
    right_x = left_x + XW'(1);
    span_x = XW'(span);
    span_m1 = span - 1'b1;
    sink_done = draining ? ((span > CW'(1)) ? S_SORT_RD : S_EMIT_RD) : S_IDLE;
    // The worse of the two children is the one that may move up.
    pick_right = (right_x < span_x) && better(rd_data_a, rd_data_b);
    in_entry.key = req.sort_key;
    in_entry.id = req.item_id;
    req_fire = req.valid && req.ready;
    out_free = !rsp.valid || rsp.ready;
  end

  // Sequencer: next state, memory accesses and result loading.
  always_comb begin
    state_next = state;
    held_next = held;
    span_next = span;
    k_next = k;
    node_next = node;
    cur_next = cur;
    draining_next = draining;
    wr_en = 1'b0;
    wr_addr = node;
    wr_data = cur;
    rd_addr_a = '0;
    rd_addr_b = '0;
    out_load = 1'b0;
    ld_entry = rd_data_a;
    ld_last = 1'b0;
    ld_none = 1'b0;
    req.ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req_fire) begin
          unique case (func_t'(req.func))
            FUNC_OFFER: begin
              if (limit != '0) begin
                if (held < limit) begin
                  cur_next = in_entry;
                  node_next = held[AW-1:0];
                  held_next = held + 1'b1;
                  state_next = S_UP_RD;
                end else if (held != '0) begin
                  // Root is read this cycle for the replace test.
                  cur_next = in_entry;
                  state_next = S_ROOT_CMP;
                end
              end
            end
            FUNC_DRAIN: begin
              k_next = '0;
              span_next = held;
              draining_next = 1'b1;
              if (held == '0) begin
                state_next = S_EMPTY;
              end else if (held > CW'(1)) begin
                state_next = S_SORT_RD;
              end else begin
                state_next = S_EMIT_RD;
              end
            end
            FUNC_CLEAR: begin
              held_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // Sift up: read the parent, then move it down or settle the new pair.
      S_UP_RD: begin
        if (node == '0) begin
          wr_en = 1'b1;
          state_next = S_IDLE;
        end else begin
          rd_addr_a = parent;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (better(rd_data_a, cur)) begin
          wr_data = rd_data_a;
          node_next = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      // Full store: replace the root only with a strictly better pair.
      S_ROOT_CMP: begin
        if (better(cur, rd_data_a)) begin
          node_next = '0;
          span_next = held;
          draining_next = 1'b0;
          state_next = S_DN_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      // Sift down: read both children, then move the worse one up or settle.
      S_DN_RD: begin
        if (left_x >= span_x) begin
          wr_en = 1'b1;
          state_next = sink_done;
        end else begin
          rd_addr_a = left_x[AW-1:0];
          rd_addr_b = right_x[AW-1:0];
          state_next = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (better(cur, pick_right ? rd_data_b : rd_data_a)) begin
          wr_data = pick_right ? rd_data_b : rd_data_a;
          node_next = pick_right ? right_x[AW-1:0] : left_x[AW-1:0];
          state_next = S_DN_RD;
        end else begin
          state_next = sink_done;
        end
      end
      // Heapsort pass: move the root to the end of the heap and sift down.
      S_SORT_RD: begin
        rd_addr_a = '0;
        rd_addr_b = span_m1[AW-1:0];
        state_next = S_SORT_SWP;
      end
      S_SORT_SWP: begin
        wr_en = 1'b1;
        wr_addr = span_m1[AW-1:0];
        wr_data = rd_data_a;
        cur_next = rd_data_b;
        node_next = '0;
        span_next = span_m1;
        state_next = S_DN_RD;
      end
      // Emit the sorted pairs in address order.
      S_EMIT_RD: begin
        rd_addr_a = k[AW-1:0];
        state_next = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        rd_addr_a = k[AW-1:0];
        if (out_free) begin
          out_load = 1'b1;
          ld_last = (CW'(k + 1'b1) == held);
          k_next = k + 1'b1;
          if (ld_last) begin
            held_next = '0;
            draining_next = 1'b0;
            state_next = S_IDLE;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_entry = '0;
          ld_last = 1'b1;
          ld_none = 1'b1;
          draining_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register and control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      keep_limit <= 7'd64;
      held <= '0;
      draining <= 1'b0;
    end else begin
      state <= state_next;
      draining <= draining_next;
      if (cfg_wr_en) begin
        keep_limit <= cfg_wr_data;
        held <= '0;
      end else begin
        held <= held_next;
      end
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    span <= span_next;
    k <= k_next;
    node <= node_next;
    cur <= cur_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.out_key <= ld_entry.key;
      rsp.out_id <= ld_entry.id;
      rsp.last <= ld_last;
      rsp.none_held <= ld_none;
    end
  end

  // The held count never exceeds the store.
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(CAPACITY))
    else $error("held count beyond capacity");

  // The heap memory is written only while a request is in work.
  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state != S_IDLE))
    else $error("heap write while idle");

  // Sift down only ever visits nodes inside the current heap.
  a_sink_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == S_DN_RD) |-> (XW'(node) < span_x))
    else $error("sift node outside heap");

  // The final pair of a drain empties the store.
  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_WAIT && out_load && ld_last) |=> (held == '0))
    else $error("store not empty after drain");

  // A result is loaded only when the output register can take it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result overwritten before it was taken");

endmodule

[rtl/core/bth_store.sv]
// Heap storage: one write port and two registered read ports.
module bth_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  bth_pkg::entry_t wr_data,
  input  logic [AW-1:0]   rd_addr_a,
  input  logic [AW-1:0]   rd_addr_b,
  output bth_pkg::entry_t rd_data_a,
  output bth_pkg::entry_t rd_data_b
);
  import bth_pkg::*;

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule
